[hdl/assert_macros.svh]
// Assertion macros for the checker file of the sorted insert table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SIT_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SIT_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

[hdl/sit_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the sorted insert table.
`default_nettype none

package sit_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed field widths of the item channels.
  localparam int ACT_W    = 2;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 6;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 7;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;
  localparam int M_PAD_W  = M_DATA_W - KEY_W - CNT_W;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  // Operation codes.
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // Pointer update codes.
  localparam logic [2:0] PTR_HOLD = 3'd0;
  localparam logic [2:0] PTR_TOP  = 3'd1;
  localparam logic [2:0] PTR_POS  = 3'd2;
  localparam logic [2:0] PTR_POS1 = 3'd3;
  localparam logic [2:0] PTR_DEC  = 3'd4;
  localparam logic [2:0] PTR_INC  = 3'd5;
  localparam logic [2:0] PTR_ZERO = 3'd6;

  // Write address select codes.
  localparam logic [1:0] WA_PTR  = 2'd0;
  localparam logic [1:0] WA_UP   = 2'd1;
  localparam logic [1:0] WA_DOWN = 2'd2;

  // Write data select codes.
  localparam logic WD_RDATA = 1'b0;
  localparam logic WD_KEY   = 1'b1;

  typedef struct packed {
    logic              load;
    logic [2:0]        ptr_op;
    logic              we;
    logic [1:0]        wa_sel;
    logic              wd_sel;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              set_status;
    logic [STAT_W-1:0] status;
    logic              cap_key;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             full;
    logic             pos_ok;
    logic             pos_last;
    logic             cnt_zero;
    logic             ge;
    logic             ptr_zero;
    logic             ptr_last;
    logic             out_free;
  } stat_t;

endpackage

`default_nettype wire

[hdl/sorted_insert_table.sv]
// Top level of the sorted insert table: stream ports, controller and datapath.
//
//   Channel   Direction  Handshake            Contents
//   s_*       in         s_tvalid / s_tready  operation item: action, key, position
//   m_*       out        m_tvalid / m_tready  result item: key, status, count
//   cfg_*     in         cfg_we               capacity register write
//
// A rejected or unused item goes straight to the result and a lookup reads one entry. An
// insert shifts the entries from the top down to its landing position up by one, and a
// remove shifts those above its position down by one, one entry per cycle over the
// single write port of the entry RAM. Reset clears the count, sets the capacity to 64
// and empties the output register; the entries themselves are not cleared. A stalled
// result sits in the output register while the next item is taken.
`default_nettype none

module sorted_insert_table #(
  parameter int DEPTH     = sit_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = sit_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Input item.
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [sit_pkg::S_DATA_W-1:0]   s_tdata,  // key_in[31:0], position[37:32], pad
  input  wire logic [sit_pkg::ACT_W-1:0]      s_tuser,  // action[1:0]
  // Result item.
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [sit_pkg::M_DATA_W-1:0]   m_tdata,  // key_out[31:0], count_out[38:32], pad
  output logic      [sit_pkg::STAT_W-1:0]     m_tuser,  // status[1:0]
  // Capacity register.
  input  wire logic                           cfg_we,
  input  wire logic [sit_pkg::CNT_W-1:0]      cfg_wdata
);

  sit_pkg::cmd_t  cmd;
  sit_pkg::stat_t stat;

  logic [sit_pkg::KEY_W-1:0] out_key;
  logic [sit_pkg::CNT_W-1:0] out_count;

  // The controller only accepts an item when idle; every operation is walked
  // through its states and ends by loading the output register.
  sit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath unpacks fields on the accept cycle, walks the entry RAM and
  // keeps the count, capacity and result registers.
  sit_dpath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_action  (s_tuser),
    .in_key     (s_tdata[sit_pkg::KEY_W-1:0]),
    .in_pos     (s_tdata[sit_pkg::KEY_W +: sit_pkg::POS_W]),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .out_key    (out_key),
    .out_status (m_tuser),
    .out_count  (out_count),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Result fields are packed from the lowest bit up, with a zero pad on top.
  assign m_tdata = {{sit_pkg::M_PAD_W{1'b0}}, out_count, out_key};

endmodule

`default_nettype wire

[hdl/sit_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module sit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/sit_ctrl.sv]
// Controller state machine of the sorted insert table.
`default_nettype none

module sit_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire sit_pkg::stat_t stat,
  output sit_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECODE    = 3'd1;
  localparam logic [2:0] S_INS_SCAN  = 3'd2;
  localparam logic [2:0] S_INS_LAST  = 3'd3;
  localparam logic [2:0] S_LOOK_WAIT = 3'd4;
  localparam logic [2:0] S_REM_SHIFT = 3'd5;
  localparam logic [2:0] S_RESULT    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.ptr_op     = sit_pkg::PTR_HOLD;
    cmd.wa_sel     = sit_pkg::WA_PTR;
    cmd.wd_sel     = sit_pkg::WD_RDATA;
    cmd.status     = sit_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.action)
          sit_pkg::ACT_INSERT: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = sit_pkg::ST_FULL;
              state_next     = S_RESULT;
            end else if (stat.cnt_zero) begin
              cmd.ptr_op = sit_pkg::PTR_ZERO;
              state_next = S_INS_LAST;
            end else begin
              cmd.ptr_op = sit_pkg::PTR_TOP;
              state_next = S_INS_SCAN;
            end
          end
          sit_pkg::ACT_LOOKUP: begin
            if (!stat.pos_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = sit_pkg::ST_RANGE;
              state_next     = S_RESULT;
            end else begin
              cmd.ptr_op = sit_pkg::PTR_POS;
              state_next = S_LOOK_WAIT;
            end
          end
          sit_pkg::ACT_REMOVE: begin
            if (!stat.pos_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = sit_pkg::ST_RANGE;
              state_next     = S_RESULT;
            end else if (stat.pos_last) begin
              cmd.cnt_dec = 1'b1;
              state_next  = S_RESULT;
            end else begin
              cmd.ptr_op = sit_pkg::PTR_POS1;
              state_next = S_REM_SHIFT;
            end
          end
          default: begin
            state_next = S_RESULT;
          end
        endcase
      end
      S_INS_SCAN: begin
        cmd.we     = 1'b1;
        cmd.wa_sel = sit_pkg::WA_UP;
        if (stat.ge) begin
          cmd.wd_sel = sit_pkg::WD_RDATA;
          if (stat.ptr_zero) begin
            state_next = S_INS_LAST;
          end else begin
            cmd.ptr_op = sit_pkg::PTR_DEC;
          end
        end else begin
          cmd.wd_sel  = sit_pkg::WD_KEY;
          cmd.cnt_inc = 1'b1;
          state_next  = S_RESULT;
        end
      end
      S_INS_LAST: begin
        cmd.we      = 1'b1;
        cmd.wa_sel  = sit_pkg::WA_PTR;
        cmd.wd_sel  = sit_pkg::WD_KEY;
        cmd.cnt_inc = 1'b1;
        state_next  = S_RESULT;
      end
      S_LOOK_WAIT: begin
        cmd.cap_key = 1'b1;
        state_next  = S_RESULT;
      end
      S_REM_SHIFT: begin
        cmd.we     = 1'b1;
        cmd.wa_sel = sit_pkg::WA_DOWN;
        cmd.wd_sel = sit_pkg::WD_RDATA;
        if (stat.ptr_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_RESULT;
        end else begin
          cmd.ptr_op = sit_pkg::PTR_INC;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/sit_dpath.sv]
// Datapath of the sorted insert table: entry memory, pointer, count and result registers.
`default_nettype none

module sit_dpath #(
  parameter int DEPTH     = sit_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = sit_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [sit_pkg::CNT_W-1:0]    cfg_wdata,
  input  wire logic [sit_pkg::ACT_W-1:0]    in_action,
  input  wire logic [sit_pkg::KEY_W-1:0]    in_key,
  input  wire logic [sit_pkg::POS_W-1:0]    in_pos,
  input  wire logic                         m_tready,
  output logic                              m_tvalid,
  output logic      [sit_pkg::KEY_W-1:0]    out_key,
  output logic      [sit_pkg::STAT_W-1:0]   out_status,
  output logic      [sit_pkg::CNT_W-1:0]    out_count,
  input  wire sit_pkg::cmd_t                cmd,
  output sit_pkg::stat_t                    stat
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMPW  = (CW > sit_pkg::CNT_W) ? CW : sit_pkg::CNT_W;
  localparam int KOW   = sit_pkg::KEY_W;
  localparam int CNTOW = sit_pkg::CNT_W;

  logic [sit_pkg::ACT_W-1:0]  action;
  logic [KEY_WIDTH-1:0]       key;
  logic [sit_pkg::POS_W-1:0]  pos;
  logic [CW-1:0]              cnt;
  logic [sit_pkg::CNT_W-1:0]  capacity;
  logic [AW-1:0]              ptr;
  logic [AW-1:0]              ptr_next;
  logic [KEY_WIDTH-1:0]       res_key;
  logic [sit_pkg::STAT_W-1:0] res_status;

  logic [AW-1:0]        waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [KEY_WIDTH-1:0] rdata;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      capacity <= sit_pkg::CAP_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (cmd.load) begin
      action     <= in_action;
      key        <= KEY_WIDTH'(in_key);
      pos        <= in_pos;
      res_key    <= '0;
      res_status <= sit_pkg::ST_OK;
    end else begin
      if (cmd.cap_key) begin
        res_key <= rdata;
      end
      if (cmd.set_status) begin
        res_status <= cmd.status;
      end
    end
    if (cmd.out_load) begin
      out_key    <= KOW'(res_key);
      out_status <= res_status;
      out_count  <= CNTOW'(cnt);
    end
  end

  always_comb begin
    case (cmd.ptr_op)
      sit_pkg::PTR_TOP:  ptr_next = AW'(cnt - CW'(1));
      sit_pkg::PTR_POS:  ptr_next = AW'(pos);
      sit_pkg::PTR_POS1: ptr_next = AW'(pos) + AW'(1);
      sit_pkg::PTR_DEC:  ptr_next = ptr - AW'(1);
      sit_pkg::PTR_INC:  ptr_next = ptr + AW'(1);
      sit_pkg::PTR_ZERO: ptr_next = '0;
      default:           ptr_next = ptr;
    endcase
  end

  always_comb begin
    case (cmd.wa_sel)
      sit_pkg::WA_UP:   waddr = ptr + AW'(1);
      sit_pkg::WA_DOWN: waddr = ptr - AW'(1);
      default:          waddr = ptr;
    endcase
  end

  assign wdata = (cmd.wd_sel == sit_pkg::WD_KEY) ? key : rdata;

  // The read address follows the pointer's next value, so rdata always holds
  // the entry at the current pointer.
  sit_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr_next),
    .rdata (rdata)
  );

  always_comb begin
    stat.action   = action;
    stat.full     = (CMPW'(cnt) >= CMPW'(capacity)) || (cnt == CW'(DEPTH));
    stat.pos_ok   = CMPW'(pos) < CMPW'(cnt);
    stat.pos_last = (CMPW'(pos) + CMPW'(1)) == CMPW'(cnt);
    stat.cnt_zero = (cnt == '0);
    stat.ge       = (rdata >= key);
    stat.ptr_zero = (ptr == '0);
    stat.ptr_last = (CW'(ptr) + CW'(1)) == cnt;
    stat.out_free = !m_tvalid || m_tready;
  end

endmodule

`default_nettype wire

[hdl/sit_checker.sv]
// Port-level checker of the sorted insert table and its bind.
`default_nettype none

`include "assert_macros.svh"

module sit_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [sit_pkg::M_DATA_W-1:0] m_tdata,
  input wire logic [sit_pkg::STAT_W-1:0]   m_tuser
);

  // A stalled result stays offered.
  `SIT_ASSERT_NEXT(a_stall_holds, clk, rst, m_tvalid && !m_tready, m_tvalid)

  // An accepted item keeps the input side closed for at least the next cycle.
  `SIT_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)

  // Rejected operations never carry a key.
  `SIT_ASSERT_NOW(a_range_no_key, clk, rst,
    m_tvalid && (m_tuser == sit_pkg::ST_RANGE), m_tdata[sit_pkg::KEY_W-1:0] == '0)
  `SIT_ASSERT_NOW(a_full_no_key, clk, rst,
    m_tvalid && (m_tuser == sit_pkg::ST_FULL), m_tdata[sit_pkg::KEY_W-1:0] == '0)

endmodule

bind sorted_insert_table sit_checker u_sit_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/sorted_insert_table_tb.sv]
// Self-checking testbench for the sorted insert table: random and directed items against a predictor.
`timescale 1ns / 100ps

module sorted_insert_table_tb;
  import sit_pkg::*;

  // The item channel has no code of its own for the unused action.
  localparam logic [ACT_W-1:0] ACT_IDLE = 2'd3;
  localparam int TBL_DEPTH = 64;
  // An insert or remove walks the whole table at worst.
  localparam int SETTLE_CYCLES = TBL_DEPTH + 16;

  typedef struct packed {
    logic [KEY_W-1:0]  key_out;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count_out;
  } result_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata   = '0;
  logic [ACT_W-1:0]    s_tuser   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]   m_tuser;
  logic                cfg_we    = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata = '0;

  // Predicted contents of the table and the capacity register.
  logic [KEY_W-1:0] sorted_keys [TBL_DEPTH];
  int               key_count = 0;
  logic [CNT_W-1:0] capacity  = CAP_RESET;

  result_t pending_results[$];
  int      fail_count     = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  int      hold_left      = 0;

  sorted_insert_table DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one operation to the predicted table and returns the result it yields.
  function automatic result_t table_apply(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                                          logic [POS_W-1:0] pos);
    result_t r;
    int      limit;
    int      p;
    r.key_out = '0;
    r.status  = ST_OK;
    limit = (capacity > TBL_DEPTH) ? TBL_DEPTH : int'(capacity);
    case (act)
      ACT_INSERT: begin
        if (key_count >= limit) begin
          r.status = ST_FULL;
        end else begin
          // The new key goes in front of any equal keys.
          p = 0;
          while (p < key_count && sorted_keys[p] < key) p++;
          for (int j = key_count; j > p; j--) sorted_keys[j] = sorted_keys[j-1];
          sorted_keys[p] = key;
          key_count++;
        end
      end
      ACT_LOOKUP: begin
        if (pos < key_count) r.key_out = sorted_keys[pos];
        else r.status = ST_RANGE;
      end
      ACT_REMOVE: begin
        if (pos >= key_count) begin
          r.status = ST_RANGE;
        end else begin
          for (int j = pos; j + 1 < key_count; j++) sorted_keys[j] = sorted_keys[j+1];
          key_count--;
        end
      end
      default: ;
    endcase
    r.count_out = key_count[CNT_W-1:0];
    return r;
  endfunction

  // Offers one item and records its expected result once it is taken. Called and
  // returns at a falling edge; tvalid stays high so back-to-back items need no gap.
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                           input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W - KEY_W - POS_W){1'b0}}, pos, key};
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(table_apply(act, key, pos));
    @(negedge clk);
  endtask

  // Sender pauses until every result is back and the block has gone quiet.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    capacity = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random mix of operations; keys lean toward duplicates and extremes, positions
  // mostly hit live entries so removes and lookups do real work.
  task automatic run_mix(input int n_items, input int insert_pct);
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < insert_pct) begin
        act = ACT_INSERT;
      end else begin
        case ($urandom_range(9))
          0:          act = ACT_IDLE;
          1, 2, 3, 4: act = ACT_LOOKUP;
          default:    act = ACT_REMOVE;
        endcase
      end
      case ($urandom_range(4))
        0, 1: key = $urandom;
        2:    key = $urandom_range(15);
        3:    key = (key_count > 0) ? sorted_keys[$urandom_range(key_count - 1)] : $urandom;
        default: key = $urandom_range(1) ? (32'hFFFF_FFFF - $urandom_range(3))
                                         : $urandom_range(3);
      endcase
      if (key_count > 0 && $urandom_range(3) != 0) pos = POS_W'($urandom_range(key_count - 1));
      else if ($urandom_range(1) != 0) pos = key_count[POS_W-1:0];
      else pos = POS_W'($urandom_range(63));
      send_item(act, key, pos);
    end
  endtask

  // Empty-table errors, extreme keys, equal keys, every lookup position in use,
  // out-of-range positions and the unused action.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(ACT_LOOKUP, 32'h0, 6'd0);
    send_item(ACT_REMOVE, 32'h0, 6'd63);
    send_item(ACT_IDLE, 32'hFFFF_FFFF, 6'd63);
    send_item(ACT_INSERT, 32'h8000_0000, 6'd0);
    send_item(ACT_INSERT, 32'h0000_0000, 6'd0);
    send_item(ACT_INSERT, 32'hFFFF_FFFF, 6'd0);
    send_item(ACT_INSERT, 32'h8000_0000, 6'd63);
    send_item(ACT_INSERT, 32'h8000_0000, 6'd0);
    send_item(ACT_INSERT, 32'h0000_0000, 6'd0);
    send_item(ACT_INSERT, 32'h5555_5555, 6'd0);
    send_item(ACT_INSERT, 32'hAAAA_AAAA, 6'd0);
    for (int p = 0; p < 8; p++) send_item(ACT_LOOKUP, 32'h0, p[POS_W-1:0]);
    send_item(ACT_LOOKUP, 32'h0, 6'd8);
    send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd63);
    send_item(ACT_REMOVE, 32'h0, 6'd0);
    send_item(ACT_REMOVE, 32'h0, 6'd6);
    send_item(ACT_REMOVE, 32'h0, 6'd2);
    wait_idle();
  endtask

  // Capacity dropped below the count: inserts stay full until removes make room.
  task automatic test_capacity_below_count();
    write_capacity(7'd1);
    send_idle_pct  = 52;
    recv_stall_pct = 0;
    run_mix(60, 50);
    wait_idle();
  endtask

  task automatic test_capacity_zero();
    write_capacity(7'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 52;
    run_mix(40, 50);
    wait_idle();
  endtask

  // Capacity above the depth behaves as the depth; fill up to it and beyond.
  task automatic test_fill_to_depth();
    write_capacity(7'd127);
    send_idle_pct  = 6;
    recv_stall_pct = 6;
    run_mix(120, 90);
    wait_idle();
  endtask

  // Receiver holds off for a long stretch while items keep coming, so the output
  // register fills and the input side has to stall.
  task automatic test_output_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_left = 400;
    @(negedge clk);
    run_mix(12, 40);
    wait_idle();
  endtask

  task automatic test_full_depth_mix();
    write_capacity(7'd64);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_mix(150, 50);
    wait_idle();
  endtask

  task automatic test_draining();
    write_capacity(7'd20);
    send_idle_pct  = 6;
    recv_stall_pct = 6;
    run_mix(150, 30);
    wait_idle();
  endtask

  task automatic test_random_capacity();
    for (int k = 0; k < 2; k++) begin
      write_capacity(CNT_W'($urandom_range(1, 64)));
      send_idle_pct  = k == 0 ? 52 : 0;
      recv_stall_pct = k == 0 ? 0 : 52;
      run_mix(130, 50);
      wait_idle();
    end
  endtask

  // Receiver: random stalls, or a forced hold-off counted down here.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Each result taken is compared with the oldest expectation.
  always @(posedge clk) begin : check_result
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expected result pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[KEY_W-1:0] !== want.key_out) begin
          $error("key_out: expected %h, got %h", want.key_out, m_tdata[KEY_W-1:0]);
          fail_count++;
        end
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          fail_count++;
        end
        if (m_tdata[KEY_W +: CNT_W] !== want.count_out) begin
          $error("count_out: expected %0d, got %0d", want.count_out, m_tdata[KEY_W +: CNT_W]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_capacity_below_count();
    test_capacity_zero();
    test_fill_to_depth();
    test_output_hold();
    test_full_depth_mix();
    test_draining();
    test_random_capacity();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every item at full table length,
  // with stalls on both sides.
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/sit_pkg.sv
hdl/sit_ram.sv
hdl/sit_ctrl.sv
hdl/sit_dpath.sv
hdl/sorted_insert_table.sv
hdl/sit_checker.sv
tb/sorted_insert_table_tb.sv
